[rtl/bsfr_pkg.sv]
// ----------------------------------------------------------------------------
// bsfr_pkg: shared types and constants for the byte stuffed frame receiver
// Frame limits, status codes and the item/result structures that travel
// between the receiver top level and its frame state machine.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  // Largest payload of one frame, in destuffed bytes
  localparam int MAX_PAYLOAD = 1024;
  // Raw bytes (opening flag included) after which a frame is abandoned
  localparam int RAW_LIMIT   = 2 * MAX_PAYLOAD + 10;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int RAW_W  = $clog2(RAW_LIMIT + 1);
  localparam int CODE_W = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] FLAG_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RST   = 8'd32;

  // Input kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // End of frame status codes
  localparam logic [CODE_W-1:0] ST_SUPER_OK   = 3'd0;
  localparam logic [CODE_W-1:0] ST_DATA_OK    = 3'd1;
  localparam logic [CODE_W-1:0] ST_FRAME_ERR  = 3'd2;
  localparam logic [CODE_W-1:0] ST_HEADER_ERR = 3'd3;
  localparam logic [CODE_W-1:0] ST_DATA_ERR   = 3'd4;
  localparam logic [CODE_W-1:0] ST_TIMEOUT    = 3'd5;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] stuff_mask;
  } cfg_t;

  typedef struct packed {
    logic              is_status;
    logic [BYTE_W-1:0] payload_byte;
    logic [CODE_W-1:0] status_code;
    logic [BYTE_W-1:0] frame_address;
    logic [BYTE_W-1:0] frame_control;
    logic [LEN_W-1:0]  payload_length;
  } res_t;

endpackage

[rtl/bsfr_if.sv]
// ----------------------------------------------------------------------------
// bsfr_if: valid/ready channels of the byte stuffed frame receiver
// Input channel carries line events, result channel carries payload bytes
// and end of frame status.
// ----------------------------------------------------------------------------
interface bsfr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bsfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface bsfr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_status;
  logic [bsfr_pkg::BYTE_W-1:0] payload_byte;
  logic [bsfr_pkg::CODE_W-1:0] status_code;
  logic [bsfr_pkg::BYTE_W-1:0] frame_address;
  logic [bsfr_pkg::BYTE_W-1:0] frame_control;
  logic [bsfr_pkg::LEN_W-1:0]  payload_length;

  modport source (output valid, output is_status, output payload_byte, output status_code,
                  output frame_address, output frame_control, output payload_length,
                  input ready);
  modport sink   (input valid, input is_status, input payload_byte, input status_code,
                  input frame_address, input frame_control, input payload_length,
                  output ready);
endinterface

[rtl/bsfr_frame_fsm.sv]
// ----------------------------------------------------------------------------
// bsfr_frame_fsm: frame state and per-event decode
// Holds the frame state (hunt/in-frame, header bytes, escape, held byte,
// running XOR, counters) and turns one line event into zero or one result.
// ----------------------------------------------------------------------------
module bsfr_frame_fsm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  bsfr_pkg::item_t item,
  input  bsfr_pkg::cfg_t  cfg,
  output logic            res_valid,
  output bsfr_pkg::res_t  res
);

  localparam logic PH_HUNT  = 1'b0;
  localparam logic PH_FRAME = 1'b1;

  logic                        phase_r, phase_nxt;
  logic [1:0]                  hdr_cnt_r, hdr_cnt_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] address_r, address_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] control_r, control_nxt;
  logic                        esc_pend_r, esc_pend_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] held_r, held_nxt;
  logic                        held_vld_r, held_vld_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [bsfr_pkg::LEN_W-1:0]  pay_cnt_r, pay_cnt_nxt;
  logic [bsfr_pkg::RAW_W-1:0]  raw_cnt_r, raw_cnt_nxt;
  logic                        hdr_bad_r, hdr_bad_nxt;

  logic                        do_finish;
  logic                        emit;
  logic [bsfr_pkg::CODE_W-1:0] fin_code;
  logic [bsfr_pkg::CODE_W-1:0] close_code;
  logic [bsfr_pkg::BYTE_W-1:0] dbyte;
  logic [bsfr_pkg::RAW_W-1:0]  raw_inc;
  logic [bsfr_pkg::LEN_W-1:0]  pay_inc;

  assign raw_inc = raw_cnt_r + 1'b1;
  assign pay_inc = pay_cnt_r + 1'b1;
  assign dbyte   = esc_pend_r ? (item.rx_byte ^ cfg.stuff_mask) : item.rx_byte;

  // Status at the closing flag: length rules first, then header, then data check
  always_comb begin
    if (esc_pend_r || (hdr_cnt_r != 2'd3)) begin
      close_code = bsfr_pkg::ST_FRAME_ERR;
    end else if (!held_vld_r) begin
      close_code = hdr_bad_r ? bsfr_pkg::ST_HEADER_ERR : bsfr_pkg::ST_SUPER_OK;
    end else if (pay_cnt_r == '0) begin
      close_code = bsfr_pkg::ST_FRAME_ERR;
    end else if (hdr_bad_r) begin
      close_code = bsfr_pkg::ST_HEADER_ERR;
    end else begin
      close_code = (held_r != xor_r) ? bsfr_pkg::ST_DATA_ERR : bsfr_pkg::ST_DATA_OK;
    end
  end

  // Next state for one event
  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    address_nxt  = address_r;
    control_nxt  = control_r;
    esc_pend_nxt = esc_pend_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    xor_nxt      = xor_r;
    pay_cnt_nxt  = pay_cnt_r;
    raw_cnt_nxt  = raw_cnt_r;
    hdr_bad_nxt  = hdr_bad_r;
    do_finish    = 1'b0;
    emit         = 1'b0;
    fin_code     = bsfr_pkg::ST_SUPER_OK;

    if (step) begin
      if (item.kind == bsfr_pkg::KIND_TIMEOUT) begin
        do_finish = 1'b1;
        fin_code  = bsfr_pkg::ST_TIMEOUT;
      end else if (phase_r == PH_HUNT) begin
        // opening flag starts a fresh frame, anything else is dropped
        if (item.rx_byte == cfg.flag_value) begin
          phase_nxt    = PH_FRAME;
          hdr_cnt_nxt  = '0;
          address_nxt  = '0;
          control_nxt  = '0;
          esc_pend_nxt = 1'b0;
          held_nxt     = '0;
          held_vld_nxt = 1'b0;
          xor_nxt      = '0;
          pay_cnt_nxt  = '0;
          raw_cnt_nxt  = bsfr_pkg::RAW_W'(1);
          hdr_bad_nxt  = 1'b0;
        end
      end else if (item.rx_byte == cfg.flag_value) begin
        do_finish = 1'b1;
        fin_code  = close_code;
      end else if (raw_inc >= bsfr_pkg::RAW_W'(bsfr_pkg::RAW_LIMIT)) begin
        do_finish = 1'b1;
        fin_code  = bsfr_pkg::ST_FRAME_ERR;
      end else if (!esc_pend_r && (item.rx_byte == cfg.escape_value)) begin
        esc_pend_nxt = 1'b1;
        raw_cnt_nxt  = raw_inc;
      end else begin
        esc_pend_nxt = 1'b0;
        raw_cnt_nxt  = raw_inc;
        if (hdr_cnt_r != 2'd3) begin
          // address, control, header check
          case (hdr_cnt_r)
            2'd0:    address_nxt = dbyte;
            2'd1:    control_nxt = dbyte;
            default: hdr_bad_nxt = (dbyte != (address_r ^ control_r));
          endcase
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        end else if (held_vld_r &&
                     (pay_cnt_r >= bsfr_pkg::LEN_W'(bsfr_pkg::MAX_PAYLOAD))) begin
          do_finish = 1'b1;
          fin_code  = bsfr_pkg::ST_FRAME_ERR;
        end else begin
          // release the held byte, hold the new one
          if (held_vld_r) begin
            xor_nxt     = xor_r ^ held_r;
            pay_cnt_nxt = pay_inc;
            emit        = 1'b1;
          end
          held_nxt     = dbyte;
          held_vld_nxt = 1'b1;
        end
      end

      // every status result ends the frame
      if (do_finish) begin
        phase_nxt    = PH_HUNT;
        hdr_cnt_nxt  = '0;
        address_nxt  = '0;
        control_nxt  = '0;
        esc_pend_nxt = 1'b0;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
        xor_nxt      = '0;
        pay_cnt_nxt  = '0;
        raw_cnt_nxt  = '0;
        hdr_bad_nxt  = 1'b0;
      end
    end
  end

  // Result of this event
  always_comb begin
    res_valid          = do_finish | emit;
    res.is_status      = do_finish;
    res.payload_byte   = emit ? held_r : '0;
    res.status_code    = do_finish ? fin_code : bsfr_pkg::ST_SUPER_OK;
    res.frame_address  = address_r;
    res.frame_control  = control_r;
    res.payload_length = emit ? pay_inc : pay_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_cnt_r  <= '0;
      address_r  <= '0;
      control_r  <= '0;
      esc_pend_r <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      xor_r      <= '0;
      pay_cnt_r  <= '0;
      raw_cnt_r  <= '0;
      hdr_bad_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      address_r  <= address_nxt;
      control_r  <= control_nxt;
      esc_pend_r <= esc_pend_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      xor_r      <= xor_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      raw_cnt_r  <= raw_cnt_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
    end
  end

endmodule

[rtl/byte_stuffed_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_core: byte stuffed frame receiver
// Hunts for flags, removes escape stuffing, checks the XOR header and data
// check bytes and emits payload bytes plus one status per frame.
// ----------------------------------------------------------------------------
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid/ready      | kind, rx_byte
//   out_ch  | out | valid/ready      | is_status, payload_byte, status_code,
//           |     |                  | frame_address, frame_control, payload_length
//   cfg_*   | in  | cfg_we (no wait) | cfg_index, cfg_wdata
//
// One event per cycle while the output is not stalled: an accepted event is held
// in the input register, is decoded by the frame state machine and its result is
// registered in the output register, from which it can be taken.
// Reset (rst_n low, synchronous) restores flag/escape/mask and returns to hunting.
// A stalled output only holds the input register; the next event is taken as
// soon as the output register is taken or empty.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  bsfr_in_if.sink                        in_ch,
  bsfr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsfr_pkg::BYTE_W-1:0]    cfg_wdata
);

  bsfr_pkg::cfg_t  cfg_r;
  bsfr_pkg::item_t in_r;
  logic            in_vld_r;
  bsfr_pkg::res_t  out_r;
  logic            out_vld_r;

  logic            proceed;
  logic            res_valid;
  bsfr_pkg::res_t  res;

  // Input register advances whenever the output register can take a result
  assign proceed     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || proceed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value   <= bsfr_pkg::FLAG_RST;
      cfg_r.escape_value <= bsfr_pkg::ESCAPE_RST;
      cfg_r.stuff_mask   <= bsfr_pkg::MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bsfr_pkg::CFG_FLAG:   cfg_r.flag_value   <= cfg_wdata;
        bsfr_pkg::CFG_ESCAPE: cfg_r.escape_value <= cfg_wdata;
        bsfr_pkg::CFG_MASK:   cfg_r.stuff_mask   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.kind    <= in_ch.kind;
      in_r.rx_byte <= in_ch.rx_byte;
    end
  end

  bsfr_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proceed),
    .item      (in_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proceed) begin
      out_vld_r <= res_valid;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.is_status      = out_r.is_status;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.status_code    = out_r.status_code;
  assign out_ch.frame_address  = out_r.frame_address;
  assign out_ch.frame_control  = out_r.frame_control;
  assign out_ch.payload_length = out_r.payload_length;

  // A timeout event always turns into a timeout status transaction
  a_timeout_status: assert property (@(posedge clk) disable iff (!rst_n)
    proceed && (in_r.kind == bsfr_pkg::KIND_TIMEOUT) |=>
      out_vld_r && out_r.is_status && (out_r.status_code == bsfr_pkg::ST_TIMEOUT))
    else $error("timeout event did not produce timeout status");

  // Payload transactions carry no code and count at least one byte
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.is_status |->
      (out_r.status_code == bsfr_pkg::ST_SUPER_OK) && (out_r.payload_length != '0) &&
      (out_r.payload_length <= bsfr_pkg::LEN_W'(bsfr_pkg::MAX_PAYLOAD)))
    else $error("malformed payload transaction");

  // Status codes stay within the defined set and carry a zero byte
  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.is_status |->
      (out_r.status_code <= bsfr_pkg::ST_TIMEOUT) && (out_r.payload_byte == '0))
    else $error("malformed status transaction");

  // An event held by a stalled output stays in the input register
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proceed |=> in_vld_r && $stable(in_r))
    else $error("input register lost an event");

endmodule
